// ----- design/smsr_pkg.sv -----
// shared types and constants for the shuffled minimal standard generator
// no dependencies; imported by every module of the block but smsr_ram
package smsr_pkg;

    localparam int          TABLE_DEPTH_DEF = 32;
    localparam int          WARMUP_EXTRA    = 8;
    localparam logic [14:0] LEHMER_MUL      = 15'd16807;
    localparam logic [30:0] LEHMER_MOD      = 31'h7FFF_FFFF;
    localparam logic [30:0] NEAR_ONE_LIMIT  = 31'd2147483389;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_SEED_FOLD,
        ST_DIV,
        ST_DRAW_MUL,
        ST_DRAW_FOLD,
        ST_SWAP,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic load_seed;
        logic mul;
        logic fold;
        logic q_clear;
        logic q_step;
        logic rd;
        logic wr_fill;
        logic wr_draw;
        logic take_pick_state;
        logic take_pick_ram;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic last_pick_zero;
        logic q_done;
    } dp_status_t;

endpackage

// ----- design/shuffled_minimal_standard_random_core.sv -----
// draw: an accepted transaction runs through the slot search, the multiply/fold step,
// the table swap and the result load, at any table depth; the load waits on result_stall
// seed, or first draw after reset: the warm-up steps that fill the table come first
// one transaction in flight; the next is taken while the result register still waits
// reset: state 1, last pick 0 (first draw seeds with 1); shuffle table is not cleared
// top level of the shuffled minimal standard generator
// depends on smsr_pkg, smsr_ctrl, smsr_dp, smsr_ram
module shuffled_minimal_standard_random_core import smsr_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        action,
    input  logic [30:0] seed_value,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [30:0] sample,
    output logic        near_one
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + WARMUP_EXTRA);

    dp_cmd_t          cmd;
    dp_status_t       status;
    logic [CNT_W-1:0] fill_idx;

    smsr_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .action       (action),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd),
        .fill_idx     (fill_idx)
    );

    smsr_dp #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .CNT_W      (CNT_W)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .action     (action),
        .seed_value (seed_value),
        .cmd        (cmd),
        .fill_idx   (fill_idx),
        .status     (status),
        .sample     (sample),
        .near_one   (near_one)
    );

endmodule

// ----- design/smsr_ram.sv -----
// generic single-port-write, single-read ram with registered read data
// no dependencies
module smsr_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/smsr_ctrl.sv -----
// controller state machine: sequences seeding, warm-up, slot search and draw
// depends on smsr_pkg
module smsr_ctrl import smsr_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int CNT_W       = $clog2(TABLE_DEPTH + WARMUP_EXTRA)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  logic             action,
    output logic             result_valid,
    input  logic             result_stall,
    input  dp_status_t       status,
    output dp_cmd_t          cmd,
    output logic [CNT_W-1:0] fill_idx
);

    localparam logic [CNT_W-1:0] FILL_START = CNT_W'(TABLE_DEPTH + WARMUP_EXTRA - 1);
    localparam logic [CNT_W-1:0] DEPTH_C    = CNT_W'(TABLE_DEPTH);

    ctrl_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        item_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.q_clear = 1'b1;
                    if (action || status.last_pick_zero)
                    begin
                        // a draw before any seed starts from seed one
                        cmd.load_seed = 1'b1;
                        cnt_next      = FILL_START;
                        state_next    = ST_SEED_MUL;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_SEED_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SEED_FOLD;
            end
            ST_SEED_FOLD:
            begin
                cmd.fold    = 1'b1;
                cmd.wr_fill = (cnt_reg < DEPTH_C);
                if (cnt_reg == '0)
                begin
                    // last warm-up step lands in entry 0 and becomes the pick
                    cmd.take_pick_state = 1'b1;
                    cmd.q_clear         = 1'b1;
                    state_next          = ST_DIV;
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ST_SEED_MUL;
                end
            end
            ST_DIV:
            begin
                cmd.q_step = 1'b1;
                if (status.q_done)
                begin
                    state_next = ST_DRAW_MUL;
                end
            end
            ST_DRAW_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DRAW_FOLD;
            end
            ST_DRAW_FOLD:
            begin
                cmd.fold   = 1'b1;
                cmd.rd     = 1'b1;
                state_next = ST_SWAP;
            end
            ST_SWAP:
            begin
                cmd.take_pick_ram = 1'b1;
                cmd.wr_draw       = 1'b1;
                state_next        = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign result_valid = out_valid_reg;
    assign fill_idx     = cnt_reg;

endmodule

// ----- design/smsr_dp.sv -----
// datapath: lehmer multiply and fold, slot search, shuffle table, result register
// depends on smsr_pkg and smsr_ram
module smsr_dp import smsr_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int CNT_W       = $clog2(TABLE_DEPTH + WARMUP_EXTRA)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             action,
    input  logic [30:0]      seed_value,
    input  dp_cmd_t          cmd,
    input  logic [CNT_W-1:0] fill_idx,
    output dp_status_t       status,
    output logic [30:0]      sample,
    output logic             near_one
);

    localparam int          SLOT_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [30:0] SLOT_DIV = 31'(1 + (64'(LEHMER_MOD) - 64'd1) / TABLE_DEPTH);
    localparam logic [8:0]  RECIP    = 9'(64'h8000_0000 / 64'(SLOT_DIV));

    logic [30:0]       lehmer_reg;
    logic [30:0]       last_pick_reg;
    logic [45:0]       prod_reg;
    logic [SLOT_W-1:0] q_reg;
    logic              q_phase_reg;
    logic [30:0]       sample_reg;
    logic              near_one_reg;

    logic [30:0]       seed_raw;
    logic [30:0]       seed_fixed;
    logic [31:0]       fold_sum;
    logic [31:0]       fold_sub;
    logic [30:0]       folded;
    logic [39:0]       est_prod;
    logic [SLOT_W:0]   trial;
    logic [SLOT_W+31:0] trial_prod;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] ram_waddr;
    logic [30:0]       ram_wdata;
    logic [30:0]       ram_rdata;
    logic              ram_we;

    assign seed_raw   = action ? seed_value : 31'd0;
    // zero and the modulus itself would lock the generator at zero
    assign seed_fixed = (seed_raw == 31'd0 || seed_raw == LEHMER_MOD) ? 31'd1 : seed_raw;

    // 2^31 == 1 mod (2^31-1): fold the high part onto the low part
    assign fold_sum = {1'b0, prod_reg[30:0]} + {17'd0, prod_reg[45:31]};
    assign fold_sub = fold_sum - {1'b0, LEHMER_MOD};
    assign folded   = (fold_sum >= {1'b0, LEHMER_MOD}) ? fold_sub[30:0] : fold_sum[30:0];

    // slot search: reciprocal estimate is exact or one low, then one correction step
    assign est_prod   = 40'(last_pick_reg) * 40'(RECIP);
    assign trial      = {1'b0, q_reg} + (SLOT_W + 1)'(1);
    assign trial_prod = (SLOT_W + 32)'(trial) * (SLOT_W + 32)'(SLOT_DIV);
    assign slot       = ({1'b0, q_reg} >= (SLOT_W + 1)'(TABLE_DEPTH))
                        ? SLOT_W'(TABLE_DEPTH - 1) : q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lehmer_reg    <= 31'd1;
            last_pick_reg <= 31'd0;
        end
        else
        begin
            if (cmd.load_seed)
            begin
                lehmer_reg <= seed_fixed;
            end
            else if (cmd.fold)
            begin
                lehmer_reg <= folded;
            end
            if (cmd.take_pick_state)
            begin
                last_pick_reg <= folded;
            end
            else if (cmd.take_pick_ram)
            begin
                last_pick_reg <= ram_rdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= {15'd0, lehmer_reg} * {31'd0, LEHMER_MUL};
        end
        if (cmd.q_clear)
        begin
            q_reg       <= '0;
            q_phase_reg <= 1'b0;
        end
        else if (cmd.q_step)
        begin
            if (!q_phase_reg)
            begin
                q_reg       <= est_prod[31 +: SLOT_W];
                q_phase_reg <= 1'b1;
            end
            else if (trial_prod <= (SLOT_W + 32)'(last_pick_reg))
            begin
                q_reg <= trial[SLOT_W-1:0];
            end
        end
        if (cmd.out_load)
        begin
            sample_reg   <= last_pick_reg;
            near_one_reg <= (last_pick_reg > NEAR_ONE_LIMIT);
        end
    end

    assign ram_we    = cmd.wr_fill || cmd.wr_draw;
    assign ram_waddr = cmd.wr_fill ? fill_idx[SLOT_W-1:0] : slot;
    assign ram_wdata = cmd.wr_fill ? folded : lehmer_reg;

    smsr_ram #(
        .WIDTH(31),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd),
        .raddr (slot),
        .rdata (ram_rdata)
    );

    assign status.last_pick_zero = (last_pick_reg == 31'd0);
    assign status.q_done         = q_phase_reg;
    assign sample                = sample_reg;
    assign near_one              = near_one_reg;

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for shuffled_minimal_standard_random_core
// depends on smsr_pkg and the core; predicts every sample with its own generator copy
module testbench;
    import smsr_pkg::*;

    localparam int          DEPTH        = TABLE_DEPTH_DEF;
    localparam int unsigned SLOT_DIV     = 1 + (32'h7FFF_FFFE / DEPTH);
    localparam int          RANDOM_ITEMS = 1530;
    localparam int          IDLE_LIMIT   = 3000;
    localparam int          DRAIN_CYCLES = 2 * (DEPTH + WARMUP_EXTRA) + 20;
    localparam logic        ACT_DRAW     = 1'b0;
    localparam logic        ACT_SEED     = 1'b1;
    localparam int          NO_REF       = -1;

    typedef struct {
        logic        act;
        logic [30:0] seed;
        int          same_as;
    } stim_row_t;

    typedef struct {
        logic [30:0] sample;
        logic        near_one;
        int          same_as;
    } sample_exp_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic        action;
    logic [30:0] seed_value;
    logic        result_valid;
    logic        result_stall;
    logic [30:0] sample;
    logic        near_one;

    // predictor state
    logic [30:0] gen_state;
    logic [30:0] last_out;
    logic [30:0] shuffle_slots [DEPTH];

    sample_exp_t pending_samples [$];
    logic [30:0] seen_samples [$];
    stim_row_t   directed [20];

    bit calm;
    int errors;
    int checked;
    int near_hits;
    int n_seeds;
    int n_draws;
    int idle_cycles;
    int stall_hold;

    shuffled_minimal_standard_random_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .action       (action),
        .seed_value   (seed_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sample       (sample),
        .near_one     (near_one)
    );

    always #5 clk = ~clk;

    function automatic logic [30:0] lehmer_advance(input logic [30:0] s);
        logic [63:0] prod;
        prod = 64'(s) * 64'(LEHMER_MUL);
        return 31'(prod % 64'(LEHMER_MOD));
    endfunction

    task automatic reseed_generator(input logic [30:0] s);
        logic [30:0] start;
        start = s;
        // zero and the modulus itself would lock the generator at zero
        if (start == 31'd0 || start == LEHMER_MOD)
            start = 31'd1;
        gen_state = start;
        for (int n = DEPTH + WARMUP_EXTRA - 1; n >= 0; n--)
        begin
            gen_state = lehmer_advance(gen_state);
            if (n < DEPTH)
                shuffle_slots[n] = gen_state;
        end
        last_out = shuffle_slots[0];
    endtask

    task automatic predict_sample(input logic act, input logic [30:0] s,
                                  output sample_exp_t e);
        int unsigned slot;
        if (act == ACT_SEED)
            reseed_generator(s);
        else if (last_out == 31'd0)
            reseed_generator(31'd1);
        gen_state = lehmer_advance(gen_state);
        slot = last_out / SLOT_DIV;
        if (slot >= DEPTH)
            slot = DEPTH - 1;
        last_out = shuffle_slots[slot];
        shuffle_slots[slot] = gen_state;
        e.sample = last_out;
        e.near_one = (last_out > NEAR_ONE_LIMIT);
        e.same_as = NO_REF;
    endtask

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [30:0] random_seed();
        case ($urandom_range(9))
            0: return 31'd0;
            1: return 31'd1;
            2: return LEHMER_MOD;
            3: return LEHMER_MOD - 31'd1;
            default: return 31'($urandom);
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input logic act, input logic [30:0] s, input int same_as);
        int gap;
        sample_exp_t e;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        action <= act;
        seed_value <= s;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predict_sample(act, s, e);
        e.same_as = same_as;
        pending_samples.push_back(e);
        if (act == ACT_SEED)
            n_seeds++;
        else
            n_draws++;
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        sample_exp_t e;
        if (rst_n && result_valid && !result_stall)
        begin
            seen_samples.push_back(sample);
            if (pending_samples.size() == 0)
            begin
                $error("result with no transaction pending: sample=%0d near_one=%0b",
                       sample, near_one);
                errors++;
            end
            else
            begin
                e = pending_samples.pop_front();
                checked++;
                if (sample !== e.sample)
                begin
                    $error("sample: expected %0d, got %0d", e.sample, sample);
                    errors++;
                end
                if (near_one !== e.near_one)
                begin
                    $error("near_one: expected %0b, got %0b", e.near_one, near_one);
                    errors++;
                end
                // reseeds that must land where a seed of one lands
                if (e.same_as != NO_REF && sample !== seen_samples[e.same_as])
                begin
                    $error("sample: expected %0d (as transaction %0d), got %0d",
                           seen_samples[e.same_as], e.same_as, sample);
                    errors++;
                end
                if (near_one === 1'b1)
                    near_hits++;
            end
        end
    end

    // receiver back-pressure: free stretches alternate with stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_hold > 0)
                stall_hold--;
            else if (result_stall || calm)
            begin
                result_stall <= 1'b0;
                stall_hold = $urandom_range(1, 12);
            end
            else
            begin
                stall_hold = pick_gap();
                if (stall_hold > 0)
                    result_stall <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles, %0d samples pending",
                         IDLE_LIMIT, pending_samples.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        logic        act;
        logic [30:0] s;
        rst_n = 1'b0;
        item_valid = 1'b0;
        action = ACT_DRAW;
        seed_value = 31'd0;
        result_stall = 1'b0;
        calm = 1'b0;
        errors = 0;
        checked = 0;
        near_hits = 0;
        n_seeds = 0;
        n_draws = 0;
        idle_cycles = 0;
        stall_hold = 0;
        gen_state = 31'd1;
        last_out = 31'd0;
        foreach (shuffle_slots[i])
            shuffle_slots[i] = 31'd0;

        // first draw after reset seeds with one, so the explicit seeds of
        // zero, one and the modulus must all reproduce transaction 0
        directed = '{
            '{ACT_DRAW, 31'h0000_0000, NO_REF},
            '{ACT_DRAW, 31'h7FFF_FFFF, NO_REF},
            '{ACT_DRAW, 31'h0000_0000, NO_REF},
            '{ACT_SEED, 31'h0000_0001, 0},
            '{ACT_SEED, 31'h0000_0000, 0},
            '{ACT_SEED, 31'h7FFF_FFFF, 0},
            '{ACT_SEED, 31'h7FFF_FFFE, NO_REF},
            '{ACT_DRAW, 31'h5555_5555, NO_REF},
            '{ACT_DRAW, 31'h2AAA_AAAA, NO_REF},
            '{ACT_SEED, 31'h0000_0002, NO_REF},
            '{ACT_SEED, 31'h5555_5555, NO_REF},
            '{ACT_SEED, 31'h2AAA_AAAA, NO_REF},
            '{ACT_DRAW, 31'h0000_0000, NO_REF},
            '{ACT_SEED, 31'd16807,     NO_REF},
            '{ACT_SEED, 31'h4000_0000, NO_REF},
            '{ACT_DRAW, 31'h0000_0000, NO_REF},
            '{ACT_DRAW, 31'h7FFF_FFFF, NO_REF},
            '{ACT_DRAW, 31'h0000_0001, NO_REF},
            '{ACT_DRAW, 31'h4000_0000, NO_REF},
            '{ACT_DRAW, 31'h0000_0000, NO_REF}
        };

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_item(directed[i].act, directed[i].seed, directed[i].same_as);

        // mostly long runs of draws between occasional reseeds
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = ((i % 250) >= 200);
            if ($urandom_range(99) < 8)
            begin
                act = ACT_SEED;
                s = random_seed();
            end
            else
            begin
                act = ACT_DRAW;
                s = 31'($urandom);
            end
            send_item(act, s, NO_REF);
        end
        calm = 1'b0;
        item_valid <= 1'b0;

        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d transactions: %0d with reseed, %0d plain draws", n_seeds + n_draws,
                 n_seeds, n_draws);
        $display("%0d samples compared, %0d flagged near one", checked, near_hits);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sim.f -----
design/smsr_pkg.sv
design/smsr_ram.sv
design/smsr_ctrl.sv
design/smsr_dp.sv
design/shuffled_minimal_standard_random_core.sv
tb/sv/testbench.sv
